// File: src/tsz_pkg.sv
`default_nettype none

package tsz_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned POS_W = 4;
	localparam int unsigned ZONE_W = 4;
	localparam int unsigned TEMP_W = 16;
	localparam int unsigned IDX_W = 5;
	localparam int unsigned MASK_W = 9;

	localparam logic [BYTE_W-1:0] CRC_POLY = 8'h8C;
	localparam logic [POS_W-1:0] LAST_BYTE = 4'd8;
	localparam logic [POS_W-1:0] TEMP_LO_POS = 4'd0;
	localparam logic [POS_W-1:0] TEMP_HI_POS = 4'd1;

	localparam logic signed [TEMP_W-1:0] FAIL_TEMP = -16'sd999;
	localparam logic signed [TEMP_W-1:0] MAX_START = -16'sd9990;
	localparam logic signed [TEMP_W-1:0] MIN_START = 16'sd9990;
	localparam logic signed [IDX_W-1:0] NO_ZONE = -5'sd1;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_ABSENT  = 2'd1,
		ST_CRC_ERR = 2'd2
	} status_t;

	// One completed zone, as handed from the scratchpad reader to the statistics.
	typedef struct packed {
		logic                     done;
		status_t                  status;
		logic signed [TEMP_W-1:0] temp;
	} zone_evt_t;

	// Reflected CRC-8, one whole byte per call: eight narrow dependent steps.
	function automatic logic [BYTE_W-1:0] crc8_update(
		input logic [BYTE_W-1:0] crc_in,
		input logic [BYTE_W-1:0] data_in
	);
		logic [BYTE_W-1:0] crc;
		logic [BYTE_W-1:0] b;
		logic              mix;
		crc = crc_in;
		b = data_in;
		for (int j = 0; j < BYTE_W; j++) begin
			mix = crc[0] ^ b[0];
			crc = crc >> 1;
			if (mix) begin
				crc = crc ^ CRC_POLY;
			end
			b = b >> 1;
		end
		return crc;
	endfunction

	// raw * 10 / 16 with truncation toward zero. Negative products get a bias of
	// fifteen before the arithmetic shift so that they round up towards zero.
	function automatic logic signed [TEMP_W-1:0] convert_temp(
		input logic [BYTE_W-1:0] lo,
		input logic [BYTE_W-1:0] hi
	);
		logic signed [TEMP_W-1:0] raw;
		logic signed [TEMP_W+3:0] prod;
		logic signed [TEMP_W+3:0] biased;
		raw = $signed({hi, lo});
		prod = 20'(raw) * 20'sd10;
		biased = prod + (prod[TEMP_W+3] ? 20'sd15 : 20'sd0);
		return TEMP_W'(biased >>> 4);
	endfunction

endpackage

`default_nettype wire

// File: src/thermometer_scratchpad_zone_stats.sv
`default_nettype none

// Zone temperature statistics from thermometer scratchpads.
// Input channel (in_valid/in_ready): each request carries kind and data_byte.
// A zone is either nine scratchpad bytes (bytes 0 to 7 under CRC-8, byte 8 the
// check value) or a single absent-sensor request, which also drops any bytes
// already taken for that zone.
// Output channel (out_valid/out_ready): one result per completed zone, giving
// the zone, its temperature in tenths of a degree (-999 on failure) and status.
// The result for the last zone (NUM_ZONES-1) sets profile_done and carries the
// valid mask, the first maximum and minimum zones and their wrapping delta; the
// statistics then restart for the next profile.
// Latency: a result is presented in the cycle after the request that completes
// its zone. Throughput: one request per cycle while no result is stalled; all
// work for a byte is done between the input handshake and the single output
// register. When the receiver stalls, the held result stays put and no request
// is taken, whether or not it would complete a zone: in_ready is low exactly
// while a result waits and out_ready is low.
// Reset (arst_n low) empties the output register, returns the byte position and
// CRC to zero and the statistics to their starting values.

module thermometer_scratchpad_zone_stats #(
	parameter int unsigned NUM_ZONES = 9
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	output logic                                    in_ready,
	input  wire logic                               kind,
	input  wire logic [tsz_pkg::BYTE_W-1:0]         data_byte,
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output logic [tsz_pkg::ZONE_W-1:0]              zone,
	output logic signed [tsz_pkg::TEMP_W-1:0]       temp_x10,
	output logic [1:0]                              status,
	output logic                                    profile_done,
	output logic [tsz_pkg::MASK_W-1:0]              good_mask,
	output logic signed [tsz_pkg::IDX_W-1:0]        hottest_zone,
	output logic signed [tsz_pkg::IDX_W-1:0]        coldest_zone,
	output logic signed [tsz_pkg::TEMP_W-1:0]       spread_x10
);
	import tsz_pkg::*;

	localparam logic [ZONE_W-1:0] LAST_ZONE = ZONE_W'(NUM_ZONES - 1);

	logic      in_acc;
	zone_evt_t evt;

	// Statistics state.
	logic [ZONE_W-1:0]        zone_q;
	logic [MASK_W-1:0]        mask_q;
	logic signed [TEMP_W-1:0] max_q;
	logic signed [TEMP_W-1:0] min_q;
	logic signed [IDX_W-1:0]  max_idx_q;
	logic signed [IDX_W-1:0]  min_idx_q;

	// Output register.
	logic                     out_valid_q;
	logic [ZONE_W-1:0]        zone_out_q;
	logic signed [TEMP_W-1:0] temp_out_q;
	logic [1:0]               status_out_q;
	logic                     done_out_q;
	logic [MASK_W-1:0]        mask_out_q;
	logic signed [IDX_W-1:0]  max_out_q;
	logic signed [IDX_W-1:0]  min_out_q;
	logic signed [TEMP_W-1:0] delta_out_q;

	// Next-state values.
	logic                     zone_ok;
	logic                     is_last;
	logic                     max_upd;
	logic                     min_upd;
	logic [MASK_W-1:0]        mask_nxt;
	logic signed [TEMP_W-1:0] max_nxt;
	logic signed [TEMP_W-1:0] min_nxt;
	logic signed [IDX_W-1:0]  max_idx_nxt;
	logic signed [IDX_W-1:0]  min_idx_nxt;
	logic signed [IDX_W-1:0]  zone_idx;
	logic signed [TEMP_W-1:0] delta_nxt;

	assign in_ready = !out_valid_q || out_ready;
	assign in_acc = in_valid && in_ready;

	tsz_scratch u_scratch (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (in_acc),
		.kind      (kind),
		.data_byte (data_byte),
		.evt       (evt)
	);

	always_comb begin
		zone_ok = evt.done && (evt.status == ST_OK);
		is_last = (zone_q >= LAST_ZONE);
		zone_idx = $signed({1'b0, zone_q});
		// Zones beyond the mask width shift the bit out and leave the mask alone.
		mask_nxt = zone_ok ? (mask_q | (MASK_W'(1) << zone_q)) : mask_q;
		max_upd = zone_ok && ($signed(evt.temp) > max_q);
		min_upd = zone_ok && ($signed(evt.temp) < min_q);
		max_nxt = max_upd ? evt.temp : max_q;
		min_nxt = min_upd ? evt.temp : min_q;
		max_idx_nxt = max_upd ? zone_idx : max_idx_q;
		min_idx_nxt = min_upd ? zone_idx : min_idx_q;
		// With no maximum zone the delta is forced to zero, even if a minimum exists.
		delta_nxt = max_idx_nxt[IDX_W-1] ? '0 : TEMP_W'(max_nxt - min_nxt);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zone_q <= '0;
			mask_q <= '0;
			max_q <= MAX_START;
			min_q <= MIN_START;
			max_idx_q <= NO_ZONE;
			min_idx_q <= NO_ZONE;
		end else if (evt.done) begin
			if (is_last) begin
				zone_q <= '0;
				mask_q <= '0;
				max_q <= MAX_START;
				min_q <= MIN_START;
				max_idx_q <= NO_ZONE;
				min_idx_q <= NO_ZONE;
			end else begin
				zone_q <= zone_q + ZONE_W'(1);
				mask_q <= mask_nxt;
				max_q <= max_nxt;
				min_q <= min_nxt;
				max_idx_q <= max_idx_nxt;
				min_idx_q <= min_idx_nxt;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (evt.done) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (evt.done) begin
			zone_out_q <= zone_q;
			temp_out_q <= evt.temp;
			status_out_q <= evt.status;
			done_out_q <= is_last;
			mask_out_q <= is_last ? mask_nxt : '0;
			max_out_q <= is_last ? max_idx_nxt : '0;
			min_out_q <= is_last ? min_idx_nxt : '0;
			delta_out_q <= is_last ? delta_nxt : '0;
		end
	end

	assign out_valid = out_valid_q;
	assign zone = zone_out_q;
	assign temp_x10 = temp_out_q;
	assign status = status_out_q;
	assign profile_done = done_out_q;
	assign good_mask = mask_out_q;
	assign hottest_zone = max_out_q;
	assign coldest_zone = min_out_q;
	assign spread_x10 = delta_out_q;

`ifndef SYNTHESIS
	a_done_needs_request: assert property (@(posedge clk) disable iff (!arst_n)
		evt.done |-> in_acc)
		else $error("zone completed without an accepted request");

	a_fail_temp: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (status_out_q != ST_OK) |-> temp_out_q == FAIL_TEMP)
		else $error("failed zone does not report the failure temperature");

	a_stats_only_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !done_out_q |-> (mask_out_q == '0) && (delta_out_q == '0)
			&& (max_out_q == '0) && (min_out_q == '0))
		else $error("statistics present before the last zone");

	a_no_max_no_delta: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && done_out_q && (max_out_q == NO_ZONE) |-> delta_out_q == '0)
		else $error("delta reported without a maximum zone");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |=> out_valid_q && $stable(zone_out_q)
			&& $stable(temp_out_q))
		else $error("stalled result lost or changed");
`endif

endmodule

`default_nettype wire

// File: src/tsz_scratch.sv
`default_nettype none

module tsz_scratch (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        accept,
	input  wire logic                        kind,
	input  wire logic [tsz_pkg::BYTE_W-1:0]  data_byte,
	output tsz_pkg::zone_evt_t               evt
);
	import tsz_pkg::*;

	logic [POS_W-1:0]         pos_q;
	logic [BYTE_W-1:0]        crc_q;
	logic [BYTE_W-1:0]        temp_low_q;
	logic signed [TEMP_W-1:0] temp_q;
	logic                     at_check;

	assign at_check = (pos_q >= LAST_BYTE);

	always_comb begin
		evt.done = accept && (kind || at_check);
		if (kind) begin
			evt.status = ST_ABSENT;
		end else if (crc_q == data_byte) begin
			evt.status = ST_OK;
		end else begin
			evt.status = ST_CRC_ERR;
		end
		evt.temp = (evt.status == ST_OK) ? temp_q : FAIL_TEMP;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			crc_q <= '0;
		end else if (accept) begin
			if (kind || at_check) begin
				pos_q <= '0;
				crc_q <= '0;
			end else begin
				pos_q <= pos_q + POS_W'(1);
				crc_q <= crc8_update(crc_q, data_byte);
			end
		end
	end

	// The temperature is converted as soon as the high byte arrives, so the
	// check byte only has to select it.
	always_ff @(posedge clk) begin
		if (accept && !kind) begin
			if (pos_q == TEMP_LO_POS) begin
				temp_low_q <= data_byte;
			end
			if (pos_q == TEMP_HI_POS) begin
				temp_q <= convert_temp(temp_low_q, data_byte);
			end
		end
	end

endmodule

`default_nettype wire

// File: tb/sv/tb_top.sv
module tb_top;
	import tsz_pkg::*;

	// Nine zones, as in the default build of the block.
	localparam int unsigned ZONES = 9;
	// The limit leaves a wide margin for the slowest correct run of roughly 1250
	// requests, even with heavy idling on both sides.
	localparam int unsigned CYCLE_LIMIT = 200000;
	// A result appears in the cycle after the request that completes its zone.
	localparam int unsigned SETTLE_CYCLES = 4;
	// Keep the log readable when something is badly wrong.
	localparam int unsigned MAX_PRINTED = 100;

	localparam logic KIND_BYTE = 1'b0;
	localparam logic KIND_ABSENT = 1'b1;

	// How a zone is built by the stimulus generator.
	typedef enum int {
		ZM_GOOD,
		ZM_BAD_CRC,
		ZM_ABSENT,
		ZM_CUT_SHORT,
		ZM_NOISE
	} zone_mode_t;

	typedef struct packed {
		logic              kind;
		logic [BYTE_W-1:0] data;
	} feed_item_t;

	typedef struct packed {
		logic [ZONE_W-1:0]        zone;
		logic signed [TEMP_W-1:0] temp;
		status_t                  status;
		logic                     done;
		logic [MASK_W-1:0]        mask;
		logic signed [IDX_W-1:0]  max_z;
		logic signed [IDX_W-1:0]  min_z;
		logic signed [TEMP_W-1:0] delta;
	} zone_result_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     in_valid = 1'b0;
	logic                     kind = 1'b0;
	logic [BYTE_W-1:0]        data_byte = '0;
	logic                     out_ready = 1'b0;
	logic                     in_ready;
	logic                     out_valid;
	logic [ZONE_W-1:0]        zone;
	logic signed [TEMP_W-1:0] temp_x10;
	logic [1:0]               status;
	logic                     profile_done;
	logic [MASK_W-1:0]        good_mask;
	logic signed [IDX_W-1:0]  hottest_zone;
	logic signed [IDX_W-1:0]  coldest_zone;
	logic signed [TEMP_W-1:0] spread_x10;

	// Requests waiting to be driven, and zone results waiting to be seen.
	feed_item_t   byte_feed_q[$];
	zone_result_t zone_results_q[$];

	int unsigned mismatches = 0;
	int unsigned cycle_count = 0;
	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;

	// Shadow of the block's state: the scratchpad being read and the running
	// statistics of the current profile. Start values match reset.
	logic [POS_W-1:0]         sp_pos = '0;
	logic [BYTE_W-1:0]        sp_crc = '0;
	logic [BYTE_W-1:0]        sp_lo = '0;
	logic [BYTE_W-1:0]        sp_hi = '0;
	logic [ZONE_W-1:0]        zone_idx = '0;
	logic [MASK_W-1:0]        ok_mask = '0;
	logic signed [TEMP_W-1:0] hi_temp = MAX_START;
	logic signed [TEMP_W-1:0] lo_temp = MIN_START;
	logic signed [IDX_W-1:0]  hi_zone = NO_ZONE;
	logic signed [IDX_W-1:0]  lo_zone = NO_ZONE;

	thermometer_scratchpad_zone_stats #(
		.NUM_ZONES(ZONES)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.kind(kind),
		.data_byte(data_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.zone(zone),
		.temp_x10(temp_x10),
		.status(status),
		.profile_done(profile_done),
		.good_mask(good_mask),
		.hottest_zone(hottest_zone),
		.coldest_zone(coldest_zone),
		.spread_x10(spread_x10)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Reflected CRC-8: each data bit, least significant first, is mixed into the
	// low end of the register, which shifts right and takes the polynomial when
	// the mixed bit is set.
	function automatic logic [BYTE_W-1:0] crc8_next(
		input logic [BYTE_W-1:0] c,
		input logic [BYTE_W-1:0] d
	);
		logic [BYTE_W-1:0] acc;
		logic              fb;
		acc = c;
		for (int i = 0; i < BYTE_W; i++) begin
			fb = acc[0] ^ d[i];
			acc = {1'b0, acc[BYTE_W-1:1]} ^ (fb ? CRC_POLY : 8'h00);
		end
		return acc;
	endfunction

	// Raw reading in sixteenths of a degree to tenths; integer division in
	// SystemVerilog already truncates toward zero, negative values included.
	function automatic logic signed [TEMP_W-1:0] tenths_of(
		input logic [BYTE_W-1:0] lo,
		input logic [BYTE_W-1:0] hi
	);
		int raw;
		raw = $signed({hi, lo});
		return TEMP_W'((raw * 10) / 16);
	endfunction

	// A zone has finished: update the statistics if it read correctly, and
	// queue the result that the block should give for it. The last zone carries
	// the statistics and starts a fresh profile.
	task automatic close_zone(input logic signed [TEMP_W-1:0] t, input status_t st);
		zone_result_t r;
		logic         last;
		last = (zone_idx >= ZONES - 1);
		if (st == ST_OK) begin
			if (zone_idx < MASK_W) begin
				ok_mask[zone_idx] = 1'b1;
			end
			if (t > hi_temp) begin
				hi_temp = t;
				hi_zone = zone_idx;
			end
			if (t < lo_temp) begin
				lo_temp = t;
				lo_zone = zone_idx;
			end
		end
		r = '0;
		r.zone = zone_idx;
		r.temp = t;
		r.status = st;
		r.done = last;
		if (last) begin
			r.mask = ok_mask;
			r.max_z = hi_zone;
			r.min_z = lo_zone;
			// With no maximum zone the difference is defined as zero, even
			// when a minimum zone exists.
			r.delta = (hi_zone >= 0) ? TEMP_W'(hi_temp - lo_temp) : '0;
			zone_idx = '0;
			ok_mask = '0;
			hi_temp = MAX_START;
			lo_temp = MIN_START;
			hi_zone = NO_ZONE;
			lo_zone = NO_ZONE;
		end else begin
			zone_idx = zone_idx + 1'b1;
		end
		sp_pos = '0;
		sp_crc = '0;
		sp_lo = '0;
		sp_hi = '0;
		zone_results_q.push_back(r);
	endtask

	// One accepted request. Bytes 0 to 7 feed the CRC, the first two also hold
	// the reading; byte 8 is the check value and closes the zone. An absent
	// request closes the zone at once and drops whatever bytes were taken.
	task automatic scratchpad_step(input logic k, input logic [BYTE_W-1:0] b);
		if (k == KIND_ABSENT) begin
			close_zone(FAIL_TEMP, ST_ABSENT);
		end else if (sp_pos >= LAST_BYTE) begin
			if (sp_crc == b) begin
				close_zone(tenths_of(sp_lo, sp_hi), ST_OK);
			end else begin
				close_zone(FAIL_TEMP, ST_CRC_ERR);
			end
		end else begin
			if (sp_pos == TEMP_LO_POS) begin
				sp_lo = b;
			end else if (sp_pos == TEMP_HI_POS) begin
				sp_hi = b;
			end
			sp_crc = crc8_next(sp_crc, b);
			sp_pos = sp_pos + 1'b1;
		end
	endtask

	task automatic report_mismatch(input string what, input longint got, input longint want);
		// Every mismatch is counted; only the first ones are printed.
		if (mismatches < MAX_PRINTED) begin
			$display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
		end
		mismatches++;
	endtask

	// Queues one zone's worth of requests. A cut-short zone stops after one to
	// eight bytes and is closed by an absent request; a noise request is a lone
	// byte that shifts the framing of whatever follows.
	task automatic add_zone(input zone_mode_t m, input logic [TEMP_W-1:0] raw);
		logic [BYTE_W-1:0] pad [9];
		logic [BYTE_W-1:0] c;
		int                cut;
		c = 8'h00;
		case (m)
			ZM_ABSENT: begin
				byte_feed_q.push_back({KIND_ABSENT, 8'($urandom)});
			end
			ZM_NOISE: begin
				byte_feed_q.push_back({KIND_BYTE, 8'($urandom)});
			end
			default: begin
				pad[0] = raw[7:0];
				pad[1] = raw[15:8];
				for (int i = 2; i < 8; i++) begin
					pad[i] = 8'($urandom);
				end
				for (int i = 0; i < 8; i++) begin
					c = crc8_next(c, pad[i]);
				end
				pad[8] = (m == ZM_BAD_CRC) ? (c ^ 8'($urandom_range(1, 255))) : c;
				cut = (m == ZM_CUT_SHORT) ? $urandom_range(1, 8) : 9;
				for (int i = 0; i < cut; i++) begin
					byte_feed_q.push_back({KIND_BYTE, pad[i]});
				end
				if (m == ZM_CUT_SHORT) begin
					byte_feed_q.push_back({KIND_ABSENT, 8'($urandom)});
				end
			end
		endcase
	endtask

	// Readings: the full-scale ends, values either side of the start values of
	// the statistics, small steps that give equal temperatures (so the first
	// zone must win), small values of either sign that test truncation, and plain noise.
	function automatic logic [TEMP_W-1:0] pick_raw();
		case ($urandom_range(0, 9))
			0, 1: begin
				case ($urandom_range(0, 9))
					0: return 16'h7FFF;
					1: return 16'h8000;
					2: return 16'h0000;
					3: return 16'hFFFF;
					4: return 16'h0001;
					5: return 16'hFFF1;
					6: return 16'(15984);
					7: return 16'(-15984);
					8: return 16'(15983);
					default: return 16'(-15983);
				endcase
			end
			2, 3, 4: return 16'(($urandom_range(0, 6) - 3) * 16);
			5: return 16'($urandom_range(0, 40) - 20);
			default: return 16'($urandom);
		endcase
	endfunction

	// Waits, on falling edges, until every queued request has been taken and
	// every expected result has come back.
	task automatic wait_drained();
		do begin
			@(negedge clk);
		end while (byte_feed_q.size() != 0 || in_valid || zone_results_q.size() != 0);
	endtask

	task automatic run_random_phase(input int unsigned idle, input int unsigned stall,
		input int unsigned n);
		zone_mode_t m;
		int unsigned pick;
		send_idle_pct = idle;
		recv_stall_pct = stall;
		while (byte_feed_q.size() < n) begin
			pick = $urandom_range(0, 99);
			if (pick < 62) begin
				m = ZM_GOOD;
			end else if (pick < 74) begin
				m = ZM_BAD_CRC;
			end else if (pick < 86) begin
				m = ZM_ABSENT;
			end else if (pick < 94) begin
				m = ZM_CUT_SHORT;
			end else begin
				m = ZM_NOISE;
			end
			add_zone(m, pick_raw());
		end
		// The sender holds off here until the block has given back every result.
		wait_drained();
	endtask

	// Driver: a new request is offered only when none is held or the held one
	// is being taken at this edge, so valid and the payload stay put until then.
	always @(posedge clk or negedge arst_n) begin : driver
		feed_item_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
			kind <= KIND_BYTE;
			data_byte <= '0;
		end else if (!in_valid || in_ready) begin
			if (byte_feed_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				nxt = byte_feed_q.pop_front();
				in_valid <= 1'b1;
				kind <= nxt.kind;
				data_byte <= nxt.data;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver back-pressure at the rate of the current phase.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// Monitor: results are checked before the request of the same edge is
	// predicted, so a result that turns up with nothing outstanding is caught.
	always @(posedge clk) begin : monitor
		zone_result_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (zone_results_q.size() == 0) begin
					report_mismatch("result with none outstanding, zone", zone, -1);
				end else begin
					want = zone_results_q.pop_front();
					if (zone !== want.zone) begin
						report_mismatch("zone", zone, want.zone);
					end
					if (temp_x10 !== want.temp) begin
						report_mismatch("temp_x10", temp_x10, want.temp);
					end
					if (status !== want.status) begin
						report_mismatch("status", status, want.status);
					end
					if (profile_done !== want.done) begin
						report_mismatch("profile_done", profile_done, want.done);
					end
					if (good_mask !== want.mask) begin
						report_mismatch("good_mask", good_mask, want.mask);
					end
					if (hottest_zone !== want.max_z) begin
						report_mismatch("hottest_zone", hottest_zone, want.max_z);
					end
					if (coldest_zone !== want.min_z) begin
						report_mismatch("coldest_zone", coldest_zone, want.min_z);
					end
					if (spread_x10 !== want.delta) begin
						report_mismatch("spread_x10", spread_x10, want.delta);
					end
				end
			end
			if (in_valid && in_ready) begin
				scratchpad_step(kind, data_byte);
			end
		end
	end

	// Watchdog: a run that has not finished by the limit has lost results or
	// hung the handshake.
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed opening, no idling. First profile: zone 0 reads full-scale
		// negative, which is below the starting maximum and so can only become
		// the minimum; zone 1 is dropped by an absent request after two bytes;
		// the rest are absent. The last result then shows a minimum zone with
		// no maximum zone and a zero difference.
		add_zone(ZM_GOOD, 16'h8000);
		byte_feed_q.push_back({KIND_BYTE, 8'hFF});
		byte_feed_q.push_back({KIND_BYTE, 8'hFF});
		byte_feed_q.push_back({KIND_ABSENT, 8'hFF});
		byte_feed_q.push_back({KIND_ABSENT, 8'h00});
		for (int z = 3; z < ZONES; z++) begin
			add_zone(ZM_ABSENT, '0);
		end
		// Second profile opens with the full-scale positive reading.
		add_zone(ZM_GOOD, 16'h7FFF);
		wait_drained();

		// Random phases: free-running, sender idling, receiver stalling, both.
		run_random_phase(0, 0, 300);
		run_random_phase(71, 0, 300);
		run_random_phase(0, 71, 300);
		run_random_phase(13, 13, 300);

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
